// File: src/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the Morse lookup for the key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int COUNT_BITS   = 10;
  localparam int LEN_BITS     = 10;
  localparam int THR_BITS     = 10;
  localparam int CMP_BITS     = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam int SIDX_BITS    = 3;
  localparam int CHR_BITS     = 7;
  localparam int LIDX_BITS    = 8;
  localparam int PAT_BITS     = 5;
  localparam int CFG_IDX_BITS = 1;
  localparam int QDEPTH       = 2;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CMP_BITS-1:0]   LEN_SAT = CMP_BITS'((1 << LEN_BITS) - 1);
  localparam logic [SIDX_BITS-1:0]  MAX_SYMS = SIDX_BITS'(PAT_BITS);
  localparam logic [THR_BITS-1:0]   DOT_RST  = THR_BITS'(120);
  localparam logic [THR_BITS-1:0]   DASH_RST = THR_BITS'(250);
  localparam logic [CHR_BITS-1:0]   CHR_SPACE = CHR_BITS'(" ");

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DOT_MAX  = 1'b0,
    REG_DASH_MAX = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EVT_DOT    = 2'd0,
    EVT_DASH   = 2'd1,
    EVT_LETTER = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e         kind;
    logic [LEN_BITS-1:0] length;
  } press_evt_t;

  // Pattern bit i set: symbol i is a dash.
  function automatic logic [CHR_BITS-1:0] morse_char(
    input logic [PAT_BITS-1:0]  pat,
    input logic [SIDX_BITS-1:0] cnt
  );
    logic [CHR_BITS-1:0] c;
    c = CHR_SPACE;
    case ({cnt, pat})
      {3'd2, 5'b00010}: c = CHR_BITS'("A");
      {3'd4, 5'b00001}: c = CHR_BITS'("B");
      {3'd4, 5'b00101}: c = CHR_BITS'("C");
      {3'd3, 5'b00001}: c = CHR_BITS'("D");
      {3'd1, 5'b00000}: c = CHR_BITS'("E");
      {3'd4, 5'b00100}: c = CHR_BITS'("F");
      {3'd3, 5'b00011}: c = CHR_BITS'("G");
      {3'd4, 5'b00000}: c = CHR_BITS'("H");
      {3'd2, 5'b00000}: c = CHR_BITS'("I");
      {3'd4, 5'b01110}: c = CHR_BITS'("J");
      {3'd3, 5'b00101}: c = CHR_BITS'("K");
      {3'd4, 5'b00010}: c = CHR_BITS'("L");
      {3'd2, 5'b00011}: c = CHR_BITS'("M");
      {3'd2, 5'b00001}: c = CHR_BITS'("N");
      {3'd3, 5'b00111}: c = CHR_BITS'("O");
      {3'd4, 5'b00110}: c = CHR_BITS'("P");
      {3'd4, 5'b01011}: c = CHR_BITS'("Q");
      {3'd3, 5'b00010}: c = CHR_BITS'("R");
      {3'd3, 5'b00000}: c = CHR_BITS'("S");
      {3'd1, 5'b00001}: c = CHR_BITS'("T");
      {3'd3, 5'b00100}: c = CHR_BITS'("U");
      {3'd4, 5'b01000}: c = CHR_BITS'("V");
      {3'd3, 5'b00110}: c = CHR_BITS'("W");
      {3'd4, 5'b01001}: c = CHR_BITS'("X");
      {3'd4, 5'b01101}: c = CHR_BITS'("Y");
      {3'd4, 5'b00011}: c = CHR_BITS'("Z");
      {3'd5, 5'b11111}: c = CHR_BITS'("0");
      {3'd5, 5'b11110}: c = CHR_BITS'("1");
      {3'd5, 5'b11100}: c = CHR_BITS'("2");
      {3'd5, 5'b11000}: c = CHR_BITS'("3");
      {3'd5, 5'b10000}: c = CHR_BITS'("4");
      {3'd5, 5'b00000}: c = CHR_BITS'("5");
      {3'd5, 5'b00001}: c = CHR_BITS'("6");
      {3'd5, 5'b00011}: c = CHR_BITS'("7");
      {3'd5, 5'b00111}: c = CHR_BITS'("8");
      {3'd5, 5'b01111}: c = CHR_BITS'("9");
      default:          c = CHR_SPACE;
    endcase
    return c;
  endfunction

endpackage

// File: src/mkd_if.sv
// ----------------------------------------------------------------------------
// mkd_if
// Valid/ready channels for key samples and decoder events.
// ----------------------------------------------------------------------------
interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink   (input valid, input key_pressed, output ready);
endinterface

interface mkd_evt_if
  import mkd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [1:0]            event_kind;
  logic [LEN_BITS-1:0]   press_length;
  logic [SIDX_BITS-1:0]  symbol_index;
  logic [CHR_BITS-1:0]   character;
  logic [LIDX_BITS-1:0]  letter_index;

  modport source (output valid, output event_kind, output press_length,
                  output symbol_index, output character, output letter_index,
                  input ready);
  modport sink   (input valid, input event_kind, input press_length,
                  input symbol_index, input character, input letter_index,
                  output ready);
endinterface

// File: src/mkd_front.sv
// ----------------------------------------------------------------------------
// mkd_front
// Counts held ticks and classifies each finished press as dot, dash or end.
// ----------------------------------------------------------------------------
module mkd_front
  import mkd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [THR_BITS-1:0]     cfg_wdata_i,
  mkd_key_if.sink                 key_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output press_evt_t              push_data_o
);

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [THR_BITS-1:0]   dot_max_q, dash_max_q;
  logic                  accept;
  logic [CMP_BITS-1:0]   len_ext, dot_ext, dash_ext;

  assign key_i.ready = push_ready_i;
  assign accept      = key_i.valid && key_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_max_q  <= DOT_RST;
      dash_max_q <= DASH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DOT_MAX:  dot_max_q  <= cfg_wdata_i;
        REG_DASH_MAX: dash_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_ext  = CMP_BITS'(cnt_q);
    dot_ext  = CMP_BITS'(dot_max_q);
    dash_ext = CMP_BITS'(dash_max_q);

    push_valid_o = key_i.valid && !key_i.key_pressed && (cnt_q != '0);
    push_data_o.length = (len_ext > LEN_SAT) ? LEN_SAT[LEN_BITS-1:0]
                                             : len_ext[LEN_BITS-1:0];
    if (len_ext <= dot_ext) begin
      push_data_o.kind = EVT_DOT;
    end else if (len_ext <= dash_ext) begin
      push_data_o.kind = EVT_DASH;
    end else begin
      push_data_o.kind = EVT_LETTER;
    end

    cnt_d = cnt_q;
    if (accept) begin
      if (key_i.key_pressed) begin
        if (cnt_q != CNT_MAX) begin
          cnt_d = cnt_q + COUNT_BITS'(1);
        end
      end else begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_push_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_ready_i) |=> (cnt_q == '0))
    else $error("press counter not cleared after release");

  a_sat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && key_i.key_pressed && cnt_q == CNT_MAX) |=> (cnt_q == CNT_MAX))
    else $error("press counter wrapped");

endmodule

// File: src/mkd_queue.sv
// ----------------------------------------------------------------------------
// mkd_queue
// Two-entry queue of classified presses between front and back.
// ----------------------------------------------------------------------------
module mkd_queue
  import mkd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  press_evt_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output press_evt_t pop_data_o
);

  press_evt_t             mem_q [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_BITS-1:0]   cnt_q, cnt_d;
  logic                   push, pop;

  assign push_ready_o = (cnt_q != QCNT_BITS'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + QPTR_BITS'(1) : wr_q;
    rd_d  = pop ? rd_q + QPTR_BITS'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_BITS'(QDEPTH))
    else $error("queue fill count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCNT_BITS'(QDEPTH)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with fill count");

endmodule

// File: src/mkd_back.sv
// ----------------------------------------------------------------------------
// mkd_back
// Symbol buffer, letter decode and output register.
// ----------------------------------------------------------------------------
module mkd_back
  import mkd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  press_evt_t pop_data_i,
  mkd_evt_if.source  evt_o
);

  logic [PAT_BITS-1:0]  pat_q, pat_d;
  logic [SIDX_BITS-1:0] sym_cnt_q, sym_cnt_d;
  logic                 ovf_q, ovf_d;
  logic [LIDX_BITS-1:0] letters_q, letters_d;
  logic                 out_valid_q, out_valid_d;
  event_kind_e          kind_q;
  logic [LEN_BITS-1:0]  len_q;
  logic [SIDX_BITS-1:0] sidx_q, sidx_d;
  logic [CHR_BITS-1:0]  chr_q, chr_d;
  logic [LIDX_BITS-1:0] lidx_q, lidx_d;
  logic                 take;

  assign pop_ready_o = !out_valid_q || evt_o.ready;
  assign take        = pop_valid_i && pop_ready_o;

  always_comb begin
    pat_d     = pat_q;
    sym_cnt_d = sym_cnt_q;
    ovf_d     = ovf_q;
    letters_d = letters_q;
    sidx_d    = '0;
    chr_d     = '0;
    lidx_d    = '0;
    case (pop_data_i.kind)
      EVT_DOT, EVT_DASH: begin
        if (sym_cnt_q < MAX_SYMS) begin
          sidx_d    = sym_cnt_q;
          sym_cnt_d = sym_cnt_q + SIDX_BITS'(1);
          if (pop_data_i.kind == EVT_DASH) begin
            pat_d = pat_q | (PAT_BITS'(1) << sym_cnt_q);
          end
        end else begin
          sidx_d = MAX_SYMS;
          ovf_d  = 1'b1;
        end
      end
      default: begin
        chr_d     = ovf_q ? CHR_SPACE : morse_char(pat_q, sym_cnt_q);
        lidx_d    = letters_q;
        letters_d = letters_q + LIDX_BITS'(1);
        pat_d     = '0;
        sym_cnt_d = '0;
        ovf_d     = 1'b0;
      end
    endcase

    if (take) begin
      out_valid_d = 1'b1;
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q       <= '0;
      sym_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      letters_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        pat_q     <= pat_d;
        sym_cnt_q <= sym_cnt_d;
        ovf_q     <= ovf_d;
        letters_q <= letters_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= pop_data_i.kind;
      len_q  <= pop_data_i.length;
      sidx_q <= sidx_d;
      chr_q  <= chr_d;
      lidx_q <= lidx_d;
    end
  end

  assign evt_o.valid        = out_valid_q;
  assign evt_o.event_kind   = kind_q;
  assign evt_o.press_length = len_q;
  assign evt_o.symbol_index = sidx_q;
  assign evt_o.character    = chr_q;
  assign evt_o.letter_index = lidx_q;

  a_sym_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_cnt_q <= MAX_SYMS)
    else $error("symbol count beyond buffer");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (sym_cnt_q == MAX_SYMS))
    else $error("overflow mark with buffer not full");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !evt_o.ready) |-> (!take ##1 out_valid_q))
    else $error("stalled transaction replaced");

endmodule

// File: src/morse_key_decoder.sv
// ----------------------------------------------------------------------------
// morse_key_decoder
// Decodes a Morse key sampled once per tick into dot, dash and letter events.
// The block takes one key sample per clock cycle while the queue has room.
// A press counter in the front classifies each release against the dot and
// dash limits; the classified press goes through a two-entry queue to the
// back, which keeps the symbol buffer, looks up the letter and holds the
// result in an output register, so a result is presented from that register
// once the queued press is taken. Input ready falls only when the queue is
// full, which happens when the event output has been stalled.
// Threshold registers may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module morse_key_decoder
  import mkd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [THR_BITS-1:0]     cfg_wdata_i,
  mkd_key_if.sink                 key_i,
  mkd_evt_if.source               evt_o
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  press_evt_t push_data, pop_data;

  mkd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .key_i        (key_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mkd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mkd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .evt_o       (evt_o)
  );

endmodule
